### src/pip_pkg.sv
// Shared types and constants for the point-in-polygon tester.
// Holds vertex store geometry, coordinate widths, command codes and controller states.
// No dependencies.
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W        = $clog2(MAX_VERTICES + 2);
    localparam int MIN_VERTICES = 3;

    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;
    localparam int WORD_W = LAT_W + LON_W;
    localparam int IN_TDATA_W  = ((WORD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;
    localparam int CMD_W  = 2;
    localparam int PROD_W = (LAT_W + 1) + (LON_W + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

endpackage

### src/point_in_polygon_test.sv
// Point-in-polygon tester, top level: vertex store memory, edge pipeline and controller.
// Depends on pip_pkg for widths, command codes and state type.
//
// Usage:
//   Input stream s_*: s_tuser[1:0] is the command (clear, append vertex, query point);
//   s_tdata carries latitude in [30:0] and longitude in [62:31], both signed.
//   Clear and append give no result; appends beyond the
//   store capacity are dropped. Every query returns one result transaction on m_*:
//   m_tdata[0] inside flag, m_tdata[1] polygon valid (three or more vertices).
//   A query over n >= 3 vertices reads the vertex memory once per cycle, n + 1 reads
//   (the closing vertex first), then drains the compare pipeline. With fewer than
//   three vertices the query skips the memory reads and goes straight to the done
//   state. The single read port of the vertex memory sets the rate of one edge per
//   cycle; one query runs at a time. Input is taken again as soon as the finished
//   result sits in the output register, even while the receiver stalls; a stalled
//   result holds until taken. Reset empties the polygon and drops any pending
//   result; memory contents stay undefined until written.
module point_in_polygon_test (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [30:0] latitude, [62:31] longitude, [63] zero
    input  logic [pip_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [1:0] command
    input  logic [pip_pkg::CMD_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] inside_res, [1] polygon_valid, [7:2] zero
    output logic [pip_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import pip_pkg::*;

    logic [WORD_W-1:0] mem [MAX_VERTICES];
    logic [WORD_W-1:0] rdata_reg;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   issue_reg, issue_next;
    logic               inside_reg, inside_next;
    logic               pvalid_reg, pvalid_next;
    logic               m_vld_reg, m_vld_next;
    logic               m_inside_reg, m_inside_next;
    logic               m_pvalid_reg, m_pvalid_next;

    logic signed [LAT_W-1:0] px_reg;
    logic signed [LON_W-1:0] py_reg;

    logic               rd_vld_reg, rd_first_reg, rd_last_reg;
    logic               s1_vld_reg, s1_last_reg, s1_cond_reg;
    logic               s2_vld_reg, s2_last_reg, s2_cond_reg, s2_dyneg_reg;
    logic signed [LAT_W:0]   s1_dpx_reg, s1_dx_reg;
    logic signed [LON_W:0]   s1_dy_reg, s1_dpy_reg;
    logic signed [PROD_W-1:0] s2_lhs_reg, s2_rhs_reg;
    logic [WORD_W-1:0]  prev_reg;

    logic               s_acc, m_free, do_issue, wr_en;
    cmd_t               cmd;
    logic [IDX_W-1:0]   addr_full;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic signed [LAT_W-1:0] xa, xb;
    logic signed [LON_W-1:0] ya, yb;
    logic               crosses;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);
    assign m_free   = !m_vld_reg || m_tready;
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {{(OUT_TDATA_W-2){1'b0}}, m_pvalid_reg, m_inside_reg};

    assign do_issue  = (state_reg == ST_RUN) && (issue_reg <= IDX_W'(cnt_reg));
    assign addr_full = (issue_reg == '0) ? (IDX_W'(cnt_reg) - IDX_W'(1))
                                         : (issue_reg - IDX_W'(1));
    assign rd_addr   = addr_full[ADDR_W-1:0];
    assign wr_en     = s_acc && (cmd == CMD_APPEND) && (cnt_reg < CNT_W'(MAX_VERTICES));
    assign wr_addr   = cnt_reg[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_tdata[WORD_W-1:0];
        end
        if (do_issue) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // current vertex (a) from memory, previous vertex (b) held
    assign xa = rdata_reg[LAT_W-1:0];
    assign ya = rdata_reg[WORD_W-1:LAT_W];
    assign xb = prev_reg[LAT_W-1:0];
    assign yb = prev_reg[WORD_W-1:LAT_W];

    always_ff @(posedge aclk) begin
        if (s_acc && (cmd == CMD_QUERY)) begin
            px_reg <= s_tdata[LAT_W-1:0];
            py_reg <= s_tdata[WORD_W-1:LAT_W];
        end
        if (rd_vld_reg) begin
            prev_reg <= rdata_reg;
        end
        s1_last_reg <= rd_last_reg;
        s1_cond_reg <= (ya > py_reg) != (yb > py_reg);
        s1_dpx_reg  <= {px_reg[LAT_W-1], px_reg} - {xa[LAT_W-1], xa};
        s1_dx_reg   <= {xb[LAT_W-1], xb} - {xa[LAT_W-1], xa};
        s1_dy_reg   <= {yb[LON_W-1], yb} - {ya[LON_W-1], ya};
        s1_dpy_reg  <= {py_reg[LON_W-1], py_reg} - {ya[LON_W-1], ya};
        s2_last_reg  <= s1_last_reg;
        s2_cond_reg  <= s1_cond_reg;
        s2_dyneg_reg <= s1_dy_reg[LON_W];
        s2_lhs_reg   <= PROD_W'(s1_dpx_reg) * PROD_W'(s1_dy_reg);
        s2_rhs_reg   <= PROD_W'(s1_dx_reg) * PROD_W'(s1_dpy_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
        end else begin
            rd_vld_reg   <= do_issue;
            rd_first_reg <= (issue_reg == '0);
            rd_last_reg  <= (issue_reg == IDX_W'(cnt_reg));
            s1_vld_reg   <= rd_vld_reg && !rd_first_reg;
            s2_vld_reg   <= s1_vld_reg;
        end
    end

    assign crosses = s2_cond_reg && (s2_dyneg_reg ? (s2_lhs_reg > s2_rhs_reg)
                                                  : (s2_lhs_reg < s2_rhs_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            issue_reg    <= '0;
            inside_reg   <= 1'b0;
            pvalid_reg   <= 1'b0;
            m_vld_reg    <= 1'b0;
            m_inside_reg <= 1'b0;
            m_pvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            issue_reg    <= issue_next;
            inside_reg   <= inside_next;
            pvalid_reg   <= pvalid_next;
            m_vld_reg    <= m_vld_next;
            m_inside_reg <= m_inside_next;
            m_pvalid_reg <= m_pvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        issue_next    = issue_reg;
        inside_next   = inside_reg;
        pvalid_next   = pvalid_reg;
        m_vld_next    = m_vld_reg && !m_tready;
        m_inside_next = m_inside_reg;
        m_pvalid_next = m_pvalid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (cmd)
                        CMD_CLEAR: begin
                            cnt_next = '0;
                        end
                        CMD_APPEND: begin
                            if (wr_en) begin
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        CMD_QUERY: begin
                            inside_next = 1'b0;
                            issue_next  = '0;
                            if (cnt_reg < CNT_W'(MIN_VERTICES)) begin
                                pvalid_next = 1'b0;
                                state_next  = ST_DONE;
                            end else begin
                                pvalid_next = 1'b1;
                                state_next  = ST_RUN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (do_issue) begin
                    issue_next = issue_reg + IDX_W'(1);
                end
                if (s2_vld_reg) begin
                    inside_next = inside_reg ^ crosses;
                    if (s2_last_reg) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (m_free) begin
                    m_vld_next    = 1'b1;
                    m_inside_next = inside_reg;
                    m_pvalid_next = pvalid_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond capacity");

    a_run_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (cnt_reg >= CNT_W'(MIN_VERTICES)))
        else $error("edge walk started on a degenerate polygon");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (issue_reg <= IDX_W'(cnt_reg) + IDX_W'(1)))
        else $error("read index ran past the stored vertices");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && s2_vld_reg && s2_last_reg) |=> (state_reg == ST_DONE))
        else $error("final edge did not complete the query");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_vld_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result dropped while receiver stalled");

endmodule
